// ===== src/rtwm_pkg.sv =====
// Shared constants, types and state codes of the thresholded window mean filter.
package rtwm_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_RADIUS  = 5;
   localparam int STORE_ROWS  = 12;

   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int SLOT_W      = $clog2(STORE_ROWS);
   localparam int ADDR_W      = SLOT_W + COL_W;
   localparam int STORE_DEPTH = STORE_ROWS * MAX_WIDTH;

   localparam int R_LIM   = (MAX_RADIUS < (STORE_ROWS - 2) / 2) ?
                            MAX_RADIUS : (STORE_ROWS - 2) / 2;
   localparam int WIN_MAX = (2 * R_LIM + 1) * (2 * R_LIM + 1);
   localparam int SUM_W   = $clog2(WIN_MAX * 255 + 1);
   localparam int CNT_W   = $clog2(WIN_MAX + 1);
   localparam int QUO_W   = 8;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH     = 2'd0,
      CSR_HEIGHT    = 2'd1,
      CSR_RADIUS    = 2'd2,
      CSR_THRESHOLD = 2'd3
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CENTRE,
      ST_WIN,
      ST_FLUSH,
      ST_EMIT
   } state_type;

   // word passed from one divider cell to the next
   typedef struct packed {
      logic             vld;
      logic [SUM_W-1:0] rem;
      logic [SUM_W-1:0] dvs;
      logic [CNT_W-1:0] cnt;
      logic [QUO_W-1:0] quo;
   } div_word_type;

endpackage

// ===== src/rtwm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rtwm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/rtwm_div_cell.sv =====
// One restoring division step: produces one quotient bit and passes the word on.
module rtwm_div_cell import rtwm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  div_word_type d_i,
   output div_word_type d_o
);

   div_word_type word_ff, word_in;

   always_comb begin
      word_in     = d_i;
      word_in.dvs = d_i.dvs >> 1;
      if (d_i.rem >= d_i.dvs) begin
         word_in.rem = d_i.rem - d_i.dvs;
         word_in.quo = {d_i.quo[QUO_W-2:0], 1'b1};
      end else begin
         word_in.quo = {d_i.quo[QUO_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.vld <= 1'b0;
      end else begin
         word_ff.vld <= word_in.vld;
      end
      word_ff.rem <= word_in.rem;
      word_ff.dvs <= word_in.dvs;
      word_ff.cnt <= word_in.cnt;
      word_ff.quo <= word_in.quo;
   end

   assign d_o = word_ff;

endmodule

// ===== src/range_thresholded_window_mean.sv =====
// Path: a word that completes a window starts a centre read and the window reads; the sum then
// passes the eight-cell divider chain and rounding into the result register. Throughput: a word
// that makes no result is taken every cycle while the sequencer is idle; one that does holds the
// input until its result is emitted, through one line store read per window pixel and the divider.
// Reset: counters and tail flag clear, registers take defaults 640/480/3/30;
// the line store is not cleared.
module range_thresholded_window_mean import rtwm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_cmd,
   input  logic [7:0]            req_pixel_in,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_pixel_out,
   output logic                  rsp_frame_last,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration
   logic [10:0] width_ff;
   logic [15:0] height_ff;
   logic [2:0]  radius_ff;
   logic [7:0]  thresh_ff;

   // stream position
   logic [15:0]       in_row_ff, out_row_ff;
   logic [COL_W-1:0]  in_col_ff, out_col_ff;
   logic [SLOT_W-1:0] in_slot_ff, out_slot_ff;
   logic              tail_ff;

   state_type state_ff, state_in;

   logic signed [3:0] dy_ff, dx_ff;
   logic              rd_vld_ff, rd_ctr_ff, rd_last_ff;
   logic [7:0]        centre_ff;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic             rsp_valid_ff;
   logic [7:0]       rsp_pixel_ff;
   logic             rsp_last_ff;
   logic [7:0]       res_ff;

   // control from the output decoder
   logic accept, issue, issue_ctr, issue_last, emit_go;

   logic [10:0] eff_w;
   logic [15:0] eff_h;
   logic [2:0]  eff_r;

   always_comb begin
      eff_w = width_ff;
      if (width_ff == 11'd0) begin
         eff_w = 11'd1;
      end else if (width_ff > 11'(MAX_WIDTH)) begin
         eff_w = 11'(MAX_WIDTH);
      end
      eff_h = (height_ff == 16'd0) ? 16'd1 : height_ff;
      eff_r = (radius_ff > 3'(R_LIM)) ? 3'(R_LIM) : radius_ff;
   end

   // ---------------- input side: next position and readiness
   logic              do_wr;
   logic [15:0]       in_row_n;
   logic [COL_W-1:0]  in_col_n;
   logic [SLOT_W-1:0] in_slot_n;
   logic              tail_n;
   logic [10:0]       in_col_inc;
   logic [16:0]       in_row_inc;
   logic [16:0]       rr;
   logic [10:0]       cc;
   logic              out_ready;

   always_comb begin
      do_wr      = accept && !req_cmd && !tail_ff;
      in_row_n   = in_row_ff;
      in_col_n   = in_col_ff;
      in_slot_n  = in_slot_ff;
      tail_n     = tail_ff;
      in_col_inc = {1'b0, in_col_ff} + 11'd1;
      in_row_inc = {1'b0, in_row_ff} + 17'd1;
      if (do_wr) begin
         if (in_col_inc >= eff_w) begin
            in_col_n = '0;
            if (in_row_inc >= {1'b0, eff_h}) begin
               in_row_n  = '0;
               in_slot_n = '0;
               tail_n    = 1'b1;
            end else begin
               in_row_n  = in_row_inc[15:0];
               in_slot_n = (in_slot_ff == SLOT_W'(STORE_ROWS - 1)) ? '0 : in_slot_ff + 1'b1;
            end
         end else begin
            in_col_n = in_col_inc[COL_W-1:0];
         end
      end
      rr = {1'b0, out_row_ff} + 17'(eff_r);
      if (rr > {1'b0, eff_h - 16'd1}) begin
         rr = {1'b0, eff_h - 16'd1};
      end
      cc = {1'b0, out_col_ff} + 11'(eff_r);
      if (cc > eff_w - 11'd1) begin
         cc = eff_w - 11'd1;
      end
      out_ready = tail_n || ({1'b0, in_row_n} > rr) ||
                  (({1'b0, in_row_n} == rr) && ({1'b0, in_col_n} > cc));
   end

   // ---------------- window address generation
   function automatic logic [15:0] mirror(input logic signed [17:0] i,
                                          input logic [16:0] dim);
      logic signed [18:0] v;
      logic signed [18:0] d;
      v = 19'(i);
      d = $signed({2'b00, dim});
      if (v < 0) begin
         v = -v - 19'sd1;
      end else if (v >= d) begin
         v = (d <<< 1) - 19'sd1 - v;
      end
      if (v < 0) begin
         v = '0;
      end
      if (v >= d) begin
         v = d - 19'sd1;
      end
      return v[15:0];
   endfunction

   logic signed [3:0]  cur_dy, cur_dx;
   logic signed [17:0] row_i, col_i, dl;
   logic [15:0]        row_y, col_x;
   logic signed [5:0]  slot_s;
   logic [ADDR_W-1:0]  raddr, waddr;
   logic [7:0]         rdata;

   always_comb begin
      cur_dy = (state_ff == ST_WIN) ? dy_ff : 4'sd0;
      cur_dx = (state_ff == ST_WIN) ? dx_ff : 4'sd0;
      row_i  = $signed({2'b00, out_row_ff}) + 18'(cur_dy);
      col_i  = $signed({8'd0, out_col_ff}) + 18'(cur_dx);
      row_y  = mirror(row_i, {1'b0, eff_h});
      col_x  = mirror(col_i, {6'd0, eff_w});
      // mirrored row stays within the radius of the output row
      dl     = $signed({2'b00, row_y}) - $signed({2'b00, out_row_ff});
      slot_s = $signed({2'b00, out_slot_ff}) + dl[5:0];
      if (slot_s < 0) begin
         slot_s = slot_s + 6'(STORE_ROWS);
      end else if (slot_s >= 6'(STORE_ROWS)) begin
         slot_s = slot_s - 6'(STORE_ROWS);
      end
      raddr = {slot_s[SLOT_W-1:0], col_x[COL_W-1:0]};
      waddr = {in_slot_ff, in_col_ff};
   end

   rtwm_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (do_wr),
      .waddr (waddr),
      .wdata (req_pixel_in),
      .raddr (raddr),
      .rdata (rdata)
   );

   // ---------------- accumulation
   logic [7:0] diff;
   logic       launch;

   always_comb begin
      diff   = (rdata > centre_ff) ? rdata - centre_ff : centre_ff - rdata;
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      if (rd_vld_ff && rd_ctr_ff) begin
         sum_in = '0;
         cnt_in = '0;
      end else if (rd_vld_ff && diff <= thresh_ff) begin
         sum_in = sum_ff + SUM_W'(rdata);
         cnt_in = cnt_ff + 1'b1;
      end
      launch = rd_vld_ff && rd_last_ff;
   end

   // ---------------- divider chain
   div_word_type chain [QUO_W+1];

   always_comb begin
      chain[0].vld = launch;
      chain[0].rem = sum_in;
      chain[0].dvs = SUM_W'(cnt_in) << (QUO_W - 1);
      chain[0].cnt = cnt_in;
      chain[0].quo = '0;
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      rtwm_div_cell u_cell (
         .clock (clock),
         .reset (reset),
         .d_i   (chain[k]),
         .d_o   (chain[k+1])
      );
   end

   logic              div_vld;
   logic [QUO_W:0]    q_rnd;
   logic [SUM_W:0]    rem2;

   always_comb begin
      div_vld = chain[QUO_W].vld;
      rem2    = {chain[QUO_W].rem, 1'b0};
      q_rnd   = {1'b0, chain[QUO_W].quo};
      // round half to even
      if (rem2 > (SUM_W+1)'(chain[QUO_W].cnt) ||
          (rem2 == (SUM_W+1)'(chain[QUO_W].cnt) && chain[QUO_W].quo[0])) begin
         q_rnd = q_rnd + 1'b1;
      end
      if (q_rnd[QUO_W]) begin
         q_rnd = {1'b0, {QUO_W{1'b1}}};
      end
   end

   // ---------------- sequencer
   logic win_last;
   assign win_last = (dy_ff == $signed({1'b0, eff_r})) && (dx_ff == $signed({1'b0, eff_r}));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && out_ready) begin
               state_in = ST_CENTRE;
            end
         end
         ST_CENTRE: state_in = ST_WIN;
         ST_WIN: begin
            if (win_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (div_vld) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      issue      = 1'b0;
      issue_ctr  = 1'b0;
      issue_last = 1'b0;
      emit_go    = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_CENTRE: begin
            issue     = 1'b1;
            issue_ctr = 1'b1;
         end
         ST_WIN: begin
            issue      = 1'b1;
            issue_last = win_last;
         end
         ST_FLUSH:  ;
         ST_EMIT:   emit_go = !rsp_valid_ff || rsp_ready;
         default:   ;
      endcase
      accept = req_valid && req_ready;
   end

   logic [10:0] out_col_inc;
   logic [16:0] out_row_inc;
   assign out_col_inc = {1'b0, out_col_ff} + 11'd1;
   assign out_row_inc = {1'b0, out_row_ff} + 17'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= 11'd640;
         height_ff    <= 16'd480;
         radius_ff    <= 3'd3;
         thresh_ff    <= 8'd30;
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         in_slot_ff   <= '0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         out_slot_ff  <= '0;
         tail_ff      <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= issue;
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         in_row_ff  <= in_row_n;
         in_col_ff  <= in_col_n;
         in_slot_ff <= in_slot_n;
         tail_ff    <= tail_n;
         if (emit_go) begin
            if (out_col_inc >= eff_w) begin
               out_col_ff <= '0;
               if (out_row_inc >= {1'b0, eff_h}) begin
                  out_row_ff  <= '0;
                  out_slot_ff <= '0;
                  tail_ff     <= 1'b0;
               end else begin
                  out_row_ff  <= out_row_inc[15:0];
                  out_slot_ff <= (out_slot_ff == SLOT_W'(STORE_ROWS - 1)) ?
                                 '0 : out_slot_ff + 1'b1;
               end
            end else begin
               out_col_ff <= out_col_inc[COL_W-1:0];
            end
         end
         if (csr_we) begin
            case (csr_idx_type'(csr_index))
               CSR_WIDTH:     width_ff  <= csr_wdata[10:0];
               CSR_HEIGHT:    height_ff <= csr_wdata[15:0];
               CSR_RADIUS:    radius_ff <= csr_wdata[2:0];
               CSR_THRESHOLD: thresh_ff <= csr_wdata[7:0];
               default:       ;
            endcase
            in_row_ff   <= '0;
            in_col_ff   <= '0;
            in_slot_ff  <= '0;
            out_row_ff  <= '0;
            out_col_ff  <= '0;
            out_slot_ff <= '0;
            tail_ff     <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rd_ctr_ff  <= issue_ctr;
      rd_last_ff <= issue_last;
      sum_ff     <= sum_in;
      cnt_ff     <= cnt_in;
      if (rd_vld_ff && rd_ctr_ff) begin
         centre_ff <= rdata;
      end
      if (state_ff == ST_CENTRE) begin
         dy_ff <= -$signed({1'b0, eff_r});
         dx_ff <= -$signed({1'b0, eff_r});
      end else if (state_ff == ST_WIN) begin
         if (dx_ff == $signed({1'b0, eff_r})) begin
            dx_ff <= -$signed({1'b0, eff_r});
            dy_ff <= dy_ff + 4'sd1;
         end else begin
            dx_ff <= dx_ff + 4'sd1;
         end
      end
      if (div_vld) begin
         res_ff <= q_rnd[QUO_W-1:0];
      end
      if (emit_go) begin
         rsp_pixel_ff <= res_ff;
         rsp_last_ff  <= (out_row_ff == eff_h - 16'd1) &&
                         ({1'b0, out_col_ff} == eff_w - 11'd1);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = rsp_pixel_ff;
   assign rsp_frame_last = rsp_last_ff;

   // the divider only finishes while the sequencer waits for it
   a_div_in_flush: assert property (@(posedge clock) disable iff (reset)
      div_vld |-> state_ff == ST_FLUSH)
      else $error("divider result outside flush state");

   // while the tail drains the input position rests at the frame start
   a_tail_pos: assert property (@(posedge clock) disable iff (reset)
      tail_ff |-> (in_row_ff == '0 && in_col_ff == '0 && in_slot_ff == '0))
      else $error("input position moved while tail pending");

   // the last window read launches a division
   a_launch: assert property (@(posedge clock) disable iff (reset)
      (rd_vld_ff && rd_last_ff) |=> chain[1].vld)
      else $error("last window read did not launch division");

   // a result is only loaded into the output slot when it is free or leaving
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_pixel_out))
      else $error("pending result overwritten");

endmodule
